// ----- design/spr_pkg.sv -----
// Shared constants and control types of the stereo polyphase resampler.
package spr_pkg;

  localparam int PHASES_DEF = 160;
  localparam int STEP_DEF   = 147;
  localparam int TAPS_DEF   = 16;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_IDX_W = 12;
  localparam int MAX_OUT    = 2;
  localparam int SHIFT      = 15;
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef struct packed {
    logic clr;    // clear accumulators at frame start
    logic tap_v;  // memory read data valid this cycle
  } mac_ctl_t;

  typedef struct packed {
    logic busy;   // product stage holds a tap
  } mac_sts_t;

endpackage

// ----- design/spr_hist_mem.sv -----
// Stereo sample history: circular buffer memory with per-entry valid bits.
module spr_hist_mem #(
  parameter int TAPS = spr_pkg::TAPS_DEF,
  localparam int HAW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [HAW-1:0]                      wr_addr,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] wr_left,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] wr_right,
  input  logic                                rd_en,
  input  logic [HAW-1:0]                      rd_addr,
  output logic signed [spr_pkg::SAMPLE_W-1:0] rd_left,
  output logic signed [spr_pkg::SAMPLE_W-1:0] rd_right
);
  import spr_pkg::*;

  logic [2*SAMPLE_W-1:0] mem [TAPS];
  logic [TAPS-1:0]       vld_r;
  logic [2*SAMPLE_W-1:0] rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_left, wr_right};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // unfilled slots read as silence
  assign rd_left  = rd_vld_r ? $signed(rd_data_r[2*SAMPLE_W-1:SAMPLE_W]) : '0;
  assign rd_right = rd_vld_r ? $signed(rd_data_r[SAMPLE_W-1:0]) : '0;

endmodule

// ----- design/spr_coef_mem.sv -----
// Polyphase coefficient store: single write port, registered read port.
module spr_coef_mem #(
  parameter int PHASES = spr_pkg::PHASES_DEF,
  parameter int TAPS   = spr_pkg::TAPS_DEF,
  localparam int DEPTH = PHASES * TAPS,
  localparam int CAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [CAW-1:0]                      wr_addr,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                                rd_en,
  input  logic [CAW-1:0]                      rd_addr,
  output logic signed [spr_pkg::SAMPLE_W-1:0] rd_data
);
  import spr_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/spr_mac.sv -----
// Two-channel multiply-accumulate with Q15 shift and 16-bit saturation.
module spr_mac #(
  parameter int TAPS = spr_pkg::TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spr_pkg::mac_ctl_t                   ctl,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] hist_left,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] hist_right,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] coef,
  output spr_pkg::mac_sts_t                   sts,
  output logic signed [spr_pkg::SAMPLE_W-1:0] sum_left,
  output logic signed [spr_pkg::SAMPLE_W-1:0] sum_right
);
  import spr_pkg::*;

  localparam int PW = 2 * SAMPLE_W;
  localparam int AW = PW + $clog2(TAPS) + 1;
  localparam logic signed [AW-1:0] MAX_V = AW'(SAT_MAX);
  localparam logic signed [AW-1:0] MIN_V = AW'(SAT_MIN);

  logic signed [PW-1:0] prod_l_r, prod_r_r;
  logic                 s2_v_r;
  logic signed [AW-1:0] acc_l_r, acc_r_r;

  function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] sh;
    sh = a >>> SHIFT;
    if (sh > MAX_V) begin
      sat_q15 = SAMPLE_W'(SAT_MAX);
    end else if (sh < MIN_V) begin
      sat_q15 = SAMPLE_W'(SAT_MIN);
    end else begin
      sat_q15 = sh[SAMPLE_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    prod_l_r <= hist_left * coef;
    prod_r_r <= hist_right * coef;
    if (ctl.clr) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (s2_v_r) begin
      acc_l_r <= acc_l_r + AW'(prod_l_r);
      acc_r_r <= acc_r_r + AW'(prod_r_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= ctl.tap_v;
    end
  end

  assign sts.busy  = s2_v_r;
  assign sum_left  = sat_q15(acc_l_r);
  assign sum_right = sat_q15(acc_r_r);

endmodule

// ----- design/stereo_polyphase_resampler_core.sv -----
// Top level of the stereo polyphase resampler: sequencer, phase and output register.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | req_type, left_in, right_in, coef_index,
//          |           |                     | coef_value
//  out_    | output    | out_valid/out_stall | left_out, right_out, last_of_run
//
// A coefficient request is written to the store when accepted. A sample request
// enters the history, then each output frame takes TAPS memory reads, the
// read/multiply pipeline and one load of the output register. The taps are read
// one at a time through the single read port of each memory. Synchronous
// reset clears the history valid bits, the phase and all control state; the
// coefficient store holds garbage until written.
// A stalled result holds in the output register; a second frame waits for it
// before loading, and a new request is taken once the last frame is loaded.
module stereo_polyphase_resampler_core #(
  parameter int PHASES = spr_pkg::PHASES_DEF,
  parameter int STEP   = spr_pkg::STEP_DEF,
  parameter int TAPS   = spr_pkg::TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_req_type,
  input  logic signed [spr_pkg::SAMPLE_W-1:0]   in_left_in,
  input  logic signed [spr_pkg::SAMPLE_W-1:0]   in_right_in,
  input  logic [spr_pkg::COEF_IDX_W-1:0]        in_coef_index,
  input  logic signed [spr_pkg::SAMPLE_W-1:0]   in_coef_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [spr_pkg::SAMPLE_W-1:0]   out_left_out,
  output logic signed [spr_pkg::SAMPLE_W-1:0]   out_right_out,
  output logic                                  out_last_of_run
);
  import spr_pkg::*;

  localparam int STORE_SIZE = PHASES * TAPS;
  localparam int CAW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int HAW = (TAPS > 1) ? $clog2(TAPS) : 1;
  // phase can climb to PHASES-1 plus one step before reduction; the width allows MAX_OUT steps
  localparam int PW  = $clog2(PHASES + MAX_OUT * STEP + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [PW-1:0]  phase_r, phase_nxt;
  logic           n_r, n_nxt;          // frames already emitted for this sample
  logic [HAW-1:0] k_r, k_nxt;          // tap counter
  logic [HAW-1:0] hp_r, hp_nxt;        // history read pointer, walks towards older
  logic [HAW-1:0] wp_r, wp_nxt;        // slot of the newest frame
  logic [CAW-1:0] ca_r, ca_nxt;        // coefficient read address
  logic           s1_v_r;              // memory read data valid
  logic           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_left_r, out_right_r;
  logic           out_last_r;

  logic           in_acc, smp_acc, cw_acc;
  logic [HAW-1:0] wp_adv;
  logic [PW-1:0]  ph_add, ph_red;
  logic           frame_last, pipe_empty, out_free, load, mac_clr;

  mac_ctl_t                   mac_ctl;
  mac_sts_t                   mac_sts;
  logic signed [SAMPLE_W-1:0] h_left, h_right, c_rd, sum_left, sum_right;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign smp_acc  = in_acc && (in_req_type == REQ_SAMPLE);
  // out-of-range addresses are dropped
  assign cw_acc   = in_acc && (in_req_type == REQ_COEF) &&
                    (32'(in_coef_index) < 32'(STORE_SIZE));

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    hp_nxt        = hp_r;
    wp_nxt        = wp_r;
    ca_nxt        = ca_r;
    mac_clr       = 1'b0;

    wp_adv     = (wp_r == HAW'(TAPS - 1)) ? '0 : wp_r + 1'b1;
    ph_add     = phase_r + PW'(STEP);
    ph_red     = (ph_add >= PW'(PHASES)) ? ph_add - PW'(PHASES) : '0;
    frame_last = (ph_add >= PW'(PHASES)) || (n_r == 1'(MAX_OUT - 1));
    pipe_empty = !s1_v_r && !mac_sts.busy;
    out_free   = !out_valid_r || !out_stall;
    load       = (state_r == ST_DONE) && pipe_empty && out_free;

    case (state_r)
      ST_IDLE: begin
        if (smp_acc) begin
          wp_nxt = wp_adv;
          hp_nxt = wp_adv;
          if (phase_r < PW'(PHASES)) begin
            state_nxt = ST_RUN;
            n_nxt     = 1'b0;
            k_nxt     = '0;
            ca_nxt    = CAW'(phase_r * TAPS);
            mac_clr   = 1'b1;
          end else begin
            // no frame due for this sample
            phase_nxt = phase_r - PW'(PHASES);
          end
        end
      end
      ST_RUN: begin
        k_nxt  = k_r + 1'b1;
        hp_nxt = (hp_r == '0) ? HAW'(TAPS - 1) : hp_r - 1'b1;
        ca_nxt = ca_r + 1'b1;
        if (k_r == HAW'(TAPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          if (frame_last) begin
            phase_nxt = ph_red;
            state_nxt = ST_IDLE;
          end else begin
            phase_nxt = ph_add;
            n_nxt     = 1'b1;
            k_nxt     = '0;
            hp_nxt    = wp_r;
            ca_nxt    = CAW'(ph_add * TAPS);
            mac_clr   = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      n_r         <= 1'b0;
      k_r         <= '0;
      hp_r        <= '0;
      wp_r        <= '0;
      ca_r        <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      hp_r        <= hp_nxt;
      wp_r        <= wp_nxt;
      ca_r        <= ca_nxt;
      s1_v_r      <= (state_r == ST_RUN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_left_r  <= sum_left;
      out_right_r <= sum_right;
      out_last_r  <= frame_last;
    end
  end

  // history is written at the accept edge, so the first tap read already sees it
  spr_hist_mem #(.TAPS(TAPS)) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (smp_acc),
    .wr_addr  (wp_adv),
    .wr_left  (in_left_in),
    .wr_right (in_right_in),
    .rd_en    (state_r == ST_RUN),
    .rd_addr  (hp_r),
    .rd_left  (h_left),
    .rd_right (h_right)
  );

  spr_coef_mem #(.PHASES(PHASES), .TAPS(TAPS)) u_coef (
    .clk     (clk),
    .wr_en   (cw_acc),
    .wr_addr (CAW'(in_coef_index)),
    .wr_data (in_coef_value),
    .rd_en   (state_r == ST_RUN),
    .rd_addr (ca_r),
    .rd_data (c_rd)
  );

  assign mac_ctl.clr   = mac_clr;
  assign mac_ctl.tap_v = s1_v_r;

  spr_mac #(.TAPS(TAPS)) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .hist_left  (h_left),
    .hist_right (h_right),
    .coef       (c_rd),
    .sts        (mac_sts),
    .sum_left   (sum_left),
    .sum_right  (sum_right)
  );

  assign out_valid       = out_valid_r;
  assign out_left_out    = out_left_r;
  assign out_right_out   = out_right_r;
  assign out_last_of_run = out_last_r;

  // read data only follows a tap-issue cycle
  a_tap_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(state_r) == ST_RUN)
    else $error("read data valid without a tap issue");

  // between requests the reduced phase stays below one step
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (phase_r < PW'(STEP)))
    else $error("phase out of range while idle");

  // the MAC pipeline has drained whenever a new request can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_v_r && !mac_sts.busy))
    else $error("MAC pipeline busy while idle");

  // the second frame of a sample is always the last one
  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && n_r) |=> out_last_r)
    else $error("second frame not flagged last");

endmodule

// ----- tb/sv/tb_stereo_polyphase_resampler_core.sv -----
// Self-checking testbench for the stereo polyphase resampler core.
`timescale 1ns / 100ps

module tb_stereo_polyphase_resampler_core;
  import spr_pkg::*;

  // Store depth, top of the address field, and cycle limit for the whole run
  localparam int STORE_DEPTH = PHASES_DEF * TAPS_DEF;
  localparam int IDX_TOP     = (1 << COEF_IDX_W) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_SAMPLES = 1600;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One request as presented on the in_ channel
  typedef struct {
    logic                  req_type;
    sample_t               left_in;
    sample_t               right_in;
    logic [COEF_IDX_W-1:0] coef_index;
    sample_t               coef_value;
  } resampler_req_t;

  // One expected stereo output frame
  typedef struct {
    sample_t left_s;
    sample_t right_s;
    logic    last_f;
  } stereo_frame_t;

  // Scoreboard: mirrors the history lines, phase and tap store, and queues the
  // frames each accepted sample request must produce.
  class resample_scoreboard;
    sample_t       left_hist  [TAPS_DEF];
    sample_t       right_hist [TAPS_DEF];
    sample_t       coef_mem   [STORE_DEPTH];
    int unsigned   phase_acc;
    stereo_frame_t frames_due [$];
    int            error_count;
    int            frames_seen;
    int            saturated_count;
    int            sample_count;
    int            coef_count;

    function new();
      foreach (left_hist[k]) begin
        left_hist[k]  = '0;
        right_hist[k] = '0;
      end
      foreach (coef_mem[a]) coef_mem[a] = '0;
      phase_acc       = 0;
      error_count     = 0;
      frames_seen     = 0;
      saturated_count = 0;
      sample_count    = 0;
      coef_count      = 0;
    endfunction

    // Tap sum for one channel at one phase, floor shift, then clamp to 16 bits
    function sample_t fir_output(bit right_ch, int unsigned ph);
      longint acc;
      longint q;
      acc = 0;
      for (int k = 0; k < TAPS_DEF; k++) begin
        acc += longint'(right_ch ? right_hist[k] : left_hist[k]) *
               longint'(coef_mem[ph * TAPS_DEF + k]);
      end
      q = acc >>> SHIFT;
      if (q > SAT_MAX) q = SAT_MAX;
      if (q < SAT_MIN) q = SAT_MIN;
      return sample_t'(q);
    endfunction

    function void note_request(resampler_req_t rq);
      stereo_frame_t fr;
      int            emitted;
      emitted = 0;
      if (rq.req_type == REQ_COEF) begin
        coef_count++;
        // addresses past the store are dropped
        if (int'(rq.coef_index) < STORE_DEPTH) coef_mem[rq.coef_index] = rq.coef_value;
      end else begin
        sample_count++;
        for (int k = TAPS_DEF - 1; k > 0; k--) begin
          left_hist[k]  = left_hist[k-1];
          right_hist[k] = right_hist[k-1];
        end
        left_hist[0]  = rq.left_in;
        right_hist[0] = rq.right_in;
        while (phase_acc < PHASES_DEF && emitted < MAX_OUT) begin
          fr.left_s  = fir_output(1'b0, phase_acc);
          fr.right_s = fir_output(1'b1, phase_acc);
          fr.last_f  = 1'b0;
          if (fr.left_s == sample_t'(SAT_MAX) || fr.left_s == sample_t'(SAT_MIN) ||
              fr.right_s == sample_t'(SAT_MAX) || fr.right_s == sample_t'(SAT_MIN))
            saturated_count++;
          frames_due.push_back(fr);
          emitted++;
          phase_acc += STEP_DEF;
        end
        if (emitted > 0) frames_due[frames_due.size()-1].last_f = 1'b1;
        if (phase_acc >= PHASES_DEF) phase_acc -= PHASES_DEF;
        else phase_acc = 0;
      end
    endfunction

    function void check_frame(sample_t l_got, sample_t r_got, logic last_got);
      stereo_frame_t fr;
      frames_seen++;
      if (frames_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected frame %0d: L=%0d R=%0d last=%0b",
                   frames_seen, l_got, r_got, last_got);
      end else begin
        fr = frames_due.pop_front();
        if (l_got !== fr.left_s || r_got !== fr.right_s || last_got !== fr.last_f) begin
          error_count++;
          if (error_count <= 10)
            $display("frame %0d mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     frames_seen, fr.left_s, fr.right_s, fr.last_f, l_got, r_got, last_got);
        end
      end
    endfunction
  endclass

  // Clock, reset and DUT ports; every input starts at a known value
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = REQ_SAMPLE;
  sample_t               in_left_in = '0;
  sample_t               in_right_in = '0;
  logic [COEF_IDX_W-1:0] in_coef_index = '0;
  sample_t               in_coef_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sample_t               out_left_out;
  sample_t               out_right_out;
  logic                  out_last_of_run;

  resample_scoreboard sb;
  bit                 steady = 1'b0;  // set: neither side idles
  int                 cycle_count = 0;

  stereo_polyphase_resampler_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .in_coef_index   (in_coef_index),
    .in_coef_value   (in_coef_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_last_of_run (out_last_of_run)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side back-pressure: roughly 31 % of cycles stalled, none while steady
  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 31);
  end

  // Result monitor. Values read just after the edge are the pre-edge ones,
  // i.e. what the core saw when it decided the handover.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_frame(out_left_out, out_right_out, out_last_of_run);
  end

  // Watchdog; the limit is many times the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still due",
               cycle_count, sb.frames_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly mid-scale values with a shift for spread, plus the rails and zero
  function automatic sample_t rand_level(int unsigned max_shift);
    sample_t v;
    case ($urandom_range(0, 9))
      0:       v = sample_t'(SAT_MAX);
      1:       v = sample_t'(SAT_MIN);
      2:       v = '0;
      default: v = sample_t'($urandom) >>> $urandom_range(0, max_shift);
    endcase
    return v;
  endfunction

  // Unused fields of each request carry random content
  function automatic resampler_req_t sample_req(sample_t l, sample_t r);
    resampler_req_t rq;
    rq.req_type   = REQ_SAMPLE;
    rq.left_in    = l;
    rq.right_in   = r;
    rq.coef_index = COEF_IDX_W'($urandom);
    rq.coef_value = sample_t'($urandom);
    return rq;
  endfunction

  function automatic resampler_req_t coef_req(int unsigned idx, sample_t val);
    resampler_req_t rq;
    rq.req_type   = REQ_COEF;
    rq.left_in    = sample_t'($urandom);
    rq.right_in   = sample_t'($urandom);
    rq.coef_index = COEF_IDX_W'(idx);
    rq.coef_value = val;
    return rq;
  endfunction

  // Present one request and hold it until the core takes it. Called right
  // after a rising edge, so all drives land as nonblocking updates there.
  task automatic send_request(input resampler_req_t rq);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq.req_type;
    in_left_in    <= rq.left_in;
    in_right_in   <= rq.right_in;
    in_coef_index <= rq.coef_index;
    in_coef_value <= rq.coef_value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(rq);
  endtask

  // Overwrite every tap row the next sample request will read
  task automatic load_due_rows(input sample_t val);
    int unsigned ph;
    ph = sb.phase_acc;
    while (ph < PHASES_DEF) begin
      for (int k = 0; k < TAPS_DEF; k++)
        send_request(coef_req(ph * TAPS_DEF + k, val));
      ph += STEP_DEF;
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tap store starts undefined: give every entry a mixed-magnitude tap
    // before any sample goes in.
    for (int a = 0; a < STORE_DEPTH; a++)
      send_request(coef_req(a, rand_level(8)));

    // Directed: rails on both channels against full-scale positive taps in
    // the rows about to be read (second request drives the sums past the
    // clamp), zero and tiny values, out-of-range writes that must not land
    // anywhere, and most-negative taps.
    for (int i = 0; i < 3; i++) begin
      load_due_rows(sample_t'(SAT_MAX));
      send_request(sample_req(sample_t'(SAT_MAX), sample_t'(SAT_MIN)));
    end
    send_request(sample_req('0, '0));
    send_request(sample_req(-16'sd1, 16'sd1));
    send_request(coef_req(STORE_DEPTH, sample_t'(SAT_MIN)));
    send_request(coef_req(IDX_TOP, '0));
    send_request(coef_req(STORE_DEPTH + 512, sample_t'(SAT_MIN)));
    send_request(sample_req(sample_t'(SAT_MIN), sample_t'(SAT_MAX)));
    send_request(coef_req(0, sample_t'(SAT_MIN)));
    send_request(coef_req(STORE_DEPTH - 1, sample_t'(SAT_MIN)));
    send_request(coef_req(TAPS_DEF - 1, '0));
    for (int i = 0; i < 8; i++)
      send_request(sample_req(i[0] ? sample_t'(SAT_MIN) : sample_t'(SAT_MAX),
                              i[1] ? sample_t'(SAT_MAX) : sample_t'(SAT_MIN)));
    send_request(sample_req('0, '0));

    // Random: a long sample stream with occasional tap rewrites and
    // out-of-range writes.
    for (int n = 0; n < RAND_SAMPLES; n++) begin
      steady = (n >= 500 && n < 800);
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 9) == 0)
          send_request(coef_req($urandom_range(STORE_DEPTH, IDX_TOP), rand_level(8)));
        else
          send_request(coef_req($urandom_range(0, STORE_DEPTH - 1), rand_level(8)));
      end
      send_request(sample_req(rand_level(6), rand_level(6)));
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then keep the monitor running for any stray result
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (sb.frames_due.size() != 0) begin
      sb.error_count += sb.frames_due.size();
      $display("%0d expected frames never arrived", sb.frames_due.size());
    end
    $display("run covered %0d sample requests and %0d tap writes; %0d frames checked",
             sb.sample_count, sb.coef_count, sb.frames_seen);
    $display("%0d frames clamped at a rail; mismatches: %0d",
             sb.saturated_count, sb.error_count);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
